FILE: rtl/core/tkvrp_pkg.sv
// ----------------------------------------------------------------------------
// tkvrp_pkg
// Types and constants of the typed key/value record parser.
// ----------------------------------------------------------------------------
package tkvrp_pkg;

  // Parse limits
  localparam int unsigned MaxEntryCount  = 16;
  localparam int unsigned MaxKeyBytes    = 16;
  localparam int unsigned MaxStringBytes = 32;

  // Width of the completed entry counter, able to hold MaxEntryCount itself
  localparam int unsigned CntW = $clog2(MaxEntryCount + 1);

  // Largest value that the entry_count output field can show
  localparam int unsigned CountFieldMax = 31;

  // Parse phase; its code is also the byte role of a parsed byte
  typedef enum logic [2:0] {
    PH_KEYLEN = 3'd0,
    PH_KEY    = 3'd1,
    PH_TYPE   = 3'd2,
    PH_INTLO  = 3'd3,
    PH_INTHI  = 3'd4,
    PH_STRLEN = 3'd5,
    PH_STR    = 3'd6,
    PH_BOOL   = 3'd7
  } phase_e;

  localparam logic [3:0] ROLE_IGNORED = 4'd8;

  // Type byte codes, also used as entry_type
  localparam logic [7:0] TYPE_INT16  = 8'd0;
  localparam logic [7:0] TYPE_STRING = 8'd1;
  localparam logic [7:0] TYPE_BOOL   = 8'd2;

  // Stop reasons
  typedef enum logic [1:0] {
    STOP_NONE      = 2'd0,
    STOP_TRUNCATED = 2'd1,
    STOP_BAD_TYPE  = 2'd2,
    STOP_LIMIT     = 2'd3
  } stop_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]         byte_role;
    logic [3:0]         entry_index;
    logic [7:0]         byte_offset;
    logic               keep;
    logic               entry_done;
    logic [1:0]         entry_type;
    logic signed [15:0] int_value;
    logic               bool_value;
    logic               end_of_buffer;
    logic [4:0]         entry_count;
    logic [1:0]         stop_reason;
  } out_t;

endpackage

FILE: rtl/core/typed_key_value_record_parser_core.sv
// ----------------------------------------------------------------------------
// typed_key_value_record_parser_core
// Parses a byte stream of typed key/value entries, one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_i) carries one buffer byte
//   per transfer, with last_byte set on the final byte of a buffer. The output
//   channel (out_valid_o, out_stall_i, out_o) returns exactly one result per
//   byte, in order: the byte's role, entry index, body offset and keep flag,
//   a pulse with the decoded value when an entry completes, and on the last
//   byte the final entry count and stop reason.
//   Each byte passes through the input register, then the result register.
//   Throughput is one byte per cycle while the receiver does not stall; the
//   parse state is a single small register set updated as a byte moves from
//   the input register to the result register.
//   While the receiver stalls, a pending result holds in the result register;
//   an empty input register still takes one more byte, then in_stall_o rises.
//   Reset empties both registers and returns the parser to the start of a
//   buffer; the state also returns there after every last byte.
// ----------------------------------------------------------------------------
module typed_key_value_record_parser_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tkvrp_pkg::in_t in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tkvrp_pkg::out_t out_o
);
  import tkvrp_pkg::*;

  // Pipeline registers
  logic  in_valid_q;
  in_t   in_q;
  logic  out_valid_q;
  out_t  out_q, out_d;

  // Parse state
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      off_q, off_d;
  logic [7:0]      low_q, low_d;
  logic            halted_q, halted_d;
  stop_e           reason_q, reason_d;

  logic out_ready;
  logic advance;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // Parse one byte
  always_comb begin
    logic [7:0] b;
    logic       done;
    logic [7:0] rem_dec;
    stop_e      rsn;

    b       = in_q.data_byte;
    done    = 1'b0;
    rem_dec = rem_q - 8'd1;

    phase_d  = phase_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    off_d    = off_q;
    low_d    = low_q;
    halted_d = halted_q;
    reason_d = reason_q;

    out_d               = '0;
    out_d.byte_role     = ROLE_IGNORED;
    out_d.end_of_buffer = in_q.last_byte;

    // Halt on the byte after the limit entry
    if (!halted_q && phase_q == PH_KEYLEN && cnt_q >= CntW'(MaxEntryCount)) begin
      halted_d = 1'b1;
      reason_d = STOP_LIMIT;
    end

    if (!halted_d) begin
      out_d.byte_role   = {1'b0, phase_q};
      out_d.entry_index = 4'(cnt_q);
      unique case (phase_q)
        PH_KEYLEN: begin
          rem_d   = b;
          off_d   = '0;
          phase_d = (b == 8'd0) ? PH_TYPE : PH_KEY;
        end
        PH_KEY: begin
          out_d.byte_offset = off_q;
          out_d.keep        = (32'(off_q) < MaxKeyBytes);
          off_d             = off_q + 8'd1;
          rem_d             = rem_dec;
          if (rem_dec == 8'd0) phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          priority if (b == TYPE_INT16) begin
            phase_d = PH_INTLO;
          end else if (b == TYPE_STRING) begin
            phase_d = PH_STRLEN;
          end else if (b == TYPE_BOOL) begin
            phase_d = PH_BOOL;
          end else begin
            halted_d = 1'b1;
            reason_d = STOP_BAD_TYPE;
            phase_d  = PH_KEYLEN;
          end
        end
        PH_INTLO: begin
          low_d   = b;
          phase_d = PH_INTHI;
        end
        PH_INTHI: begin
          done             = 1'b1;
          out_d.entry_type = TYPE_INT16[1:0];
          out_d.int_value  = {b, low_q};
        end
        PH_STRLEN: begin
          rem_d = b;
          off_d = '0;
          if (b == 8'd0) begin
            done             = 1'b1;
            out_d.entry_type = TYPE_STRING[1:0];
          end else begin
            phase_d = PH_STR;
          end
        end
        PH_STR: begin
          out_d.byte_offset = off_q;
          out_d.keep        = (32'(off_q) < MaxStringBytes);
          off_d             = off_q + 8'd1;
          rem_d             = rem_dec;
          if (rem_dec == 8'd0) begin
            done             = 1'b1;
            out_d.entry_type = TYPE_STRING[1:0];
          end
        end
        PH_BOOL: begin
          done             = 1'b1;
          out_d.entry_type = TYPE_BOOL[1:0];
          out_d.bool_value = (b != 8'd0);
        end
        default: ;
      endcase
      if (done) begin
        phase_d = PH_KEYLEN;
        rem_d   = '0;
        off_d   = '0;
        cnt_d   = cnt_q + CntW'(1);
      end
    end
    out_d.entry_done = done;

    rsn = reason_d;
    if (in_q.last_byte && !halted_d && phase_d != PH_KEYLEN) rsn = STOP_TRUNCATED;
    out_d.stop_reason = rsn;
    out_d.entry_count = (32'(cnt_d) > CountFieldMax) ? 5'(CountFieldMax) : 5'(cnt_d);

    // Start over for the next buffer
    if (in_q.last_byte) begin
      phase_d  = PH_KEYLEN;
      cnt_d    = '0;
      rem_d    = '0;
      off_d    = '0;
      low_d    = '0;
      halted_d = 1'b0;
      reason_d = STOP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_KEYLEN;
      cnt_q       <= '0;
      rem_q       <= '0;
      off_q       <= '0;
      low_q       <= '0;
      halted_q    <= 1'b0;
      reason_q    <= STOP_NONE;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_ready) out_valid_q <= in_valid_q;
      if (advance) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        rem_q    <= rem_d;
        off_q    <= off_d;
        low_q    <= low_d;
        halted_q <= halted_d;
        reason_q <= reason_d;
      end
    end
  end

  // Payload registers, held while stalled
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_q <= in_i;
    if (advance) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_done_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.entry_done |->
      out_o.byte_role == 4'(PH_INTHI) || out_o.byte_role == 4'(PH_STRLEN) ||
      out_o.byte_role == 4'(PH_STR) || out_o.byte_role == 4'(PH_BOOL))
    else $error("entry completed on a byte that cannot end an entry");

  a_ignored_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.byte_role == ROLE_IGNORED |->
      !out_o.keep && !out_o.entry_done && out_o.entry_index == 4'd0)
    else $error("ignored byte carries entry information");

  a_halt_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> reason_q == STOP_BAD_TYPE || reason_q == STOP_LIMIT)
    else $error("parser halted without a halt reason");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.last_byte |=>
      phase_q == PH_KEYLEN && cnt_q == '0 && !halted_q && reason_q == STOP_NONE)
    else $error("parse state not cleared after the last byte");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the typed key/value record parser core. Buffers of
// well-formed, truncated, bad-type and noise records stream in under random
// gaps and stalls; every result is checked against a cycle-free parse model.
// ----------------------------------------------------------------------------
module tb;
  import tkvrp_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned StreamBytes = 1250;
  localparam int unsigned DrainEvery  = 400;
  localparam int unsigned HoldAtCount = 300;
  localparam int unsigned HoldCycles  = 200;

  typedef struct packed {
    logic drain;
    in_t  item;
  } slot_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  typed_key_value_record_parser_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  slot_t      stream_q[$];
  out_t       byte_reports_q[$];
  logic [7:0] rec_q[$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // Parse state of the model
  phase_e     pp;
  logic [7:0] done_cnt;
  logic [7:0] body_left;
  logic [7:0] body_off;
  logic [7:0] lo_byte;
  logic       stopped;
  stop_e      why;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_parse();
    pp        = PH_KEYLEN;
    done_cnt  = '0;
    body_left = '0;
    body_off  = '0;
    lo_byte   = '0;
    stopped   = 1'b0;
    why       = STOP_NONE;
  endfunction

  // Advance the parse state by one byte and describe that byte
  function automatic out_t parse_byte(in_t it);
    out_t r;
    logic fin;
    r = '0;
    fin = 1'b0;
    r.byte_role = ROLE_IGNORED;
    if (!stopped && pp == PH_KEYLEN && done_cnt >= MaxEntryCount) begin
      stopped = 1'b1;
      why = STOP_LIMIT;
    end
    if (!stopped) begin
      r.byte_role = {1'b0, pp};
      r.entry_index = done_cnt[3:0];
      case (pp)
        PH_KEYLEN: begin
          body_left = it.data_byte;
          body_off = '0;
          pp = (it.data_byte == 8'd0) ? PH_TYPE : PH_KEY;
        end
        PH_KEY: begin
          r.byte_offset = body_off;
          r.keep = (body_off < MaxKeyBytes);
          body_off++;
          body_left--;
          if (body_left == 8'd0) pp = PH_TYPE;
        end
        PH_TYPE: begin
          if (it.data_byte == TYPE_INT16) pp = PH_INTLO;
          else if (it.data_byte == TYPE_STRING) pp = PH_STRLEN;
          else if (it.data_byte == TYPE_BOOL) pp = PH_BOOL;
          else begin
            stopped = 1'b1;
            why = STOP_BAD_TYPE;
            pp = PH_KEYLEN;
          end
        end
        PH_INTLO: begin
          lo_byte = it.data_byte;
          pp = PH_INTHI;
        end
        PH_INTHI: begin
          fin = 1'b1;
          r.entry_type = 2'(TYPE_INT16);
          r.int_value = {it.data_byte, lo_byte};
        end
        PH_STRLEN: begin
          body_left = it.data_byte;
          body_off = '0;
          if (it.data_byte == 8'd0) begin
            fin = 1'b1;
            r.entry_type = 2'(TYPE_STRING);
          end else begin
            pp = PH_STR;
          end
        end
        PH_STR: begin
          r.byte_offset = body_off;
          r.keep = (body_off < MaxStringBytes);
          body_off++;
          body_left--;
          if (body_left == 8'd0) begin
            fin = 1'b1;
            r.entry_type = 2'(TYPE_STRING);
          end
        end
        default: begin
          fin = 1'b1;
          r.entry_type = 2'(TYPE_BOOL);
          r.bool_value = |it.data_byte;
        end
      endcase
      r.entry_done = fin;
      if (fin) begin
        pp = PH_KEYLEN;
        body_left = '0;
        body_off = '0;
        if (done_cnt < 8'd255) done_cnt++;
      end
    end
    r.stop_reason = why;
    if (it.last_byte && !stopped && pp != PH_KEYLEN) r.stop_reason = STOP_TRUNCATED;
    r.entry_count = (done_cnt > CountFieldMax) ? 5'(CountFieldMax) : done_cnt[4:0];
    r.end_of_buffer = it.last_byte;
    if (it.last_byte) clear_parse();
    return r;
  endfunction

  // ---------------- stimulus construction ----------------

  // Mostly short, sometimes around the cap, rarely the full byte range
  function automatic int pick_len(int unsigned cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 4);
    if (r < 99) return $urandom_range(cap - 2, cap + 3);
    return 255;
  endfunction

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_key();
    int klen;
    klen = pick_len(MaxKeyBytes);
    rec_q.push_back(8'(klen));
    for (int i = 0; i < klen; i++) rec_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_entry();
    int slen;
    add_key();
    case ($urandom_range(0, 2))
      0: begin
        rec_q.push_back(TYPE_INT16);
        rec_q.push_back(edge_byte());
        rec_q.push_back(edge_byte());
      end
      1: begin
        rec_q.push_back(TYPE_STRING);
        slen = pick_len(MaxStringBytes);
        rec_q.push_back(8'(slen));
        for (int i = 0; i < slen; i++) rec_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        rec_q.push_back(TYPE_BOOL);
        rec_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'h00);
      end
    endcase
  endtask

  // Move the record bytes into the stream, flag the final one
  task automatic push_record(logic drain_first);
    slot_t s;
    for (int i = 0; i < rec_q.size(); i++) begin
      s.drain = drain_first && (i == 0);
      s.item.data_byte = rec_q[i];
      s.item.last_byte = (i == rec_q.size() - 1);
      stream_q.push_back(s);
    end
    rec_q.delete();
  endtask

  task automatic add_buffer(logic drain_first);
    int kind;
    int n;
    int keep_len;
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
    if (kind < 85) begin
      for (int i = 0; i < n; i++) add_entry();
    end
    if (kind >= 55 && kind < 70) begin
      // truncate somewhere inside the record
      keep_len = $urandom_range(1, rec_q.size());
      while (rec_q.size() > keep_len) void'(rec_q.pop_back());
    end else if (kind >= 70 && kind < 85) begin
      // unknown type, then a tail that must be ignored
      add_key();
      rec_q.push_back(8'($urandom_range(3, 255)));
      repeat ($urandom_range(0, 6)) rec_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 85) begin
      repeat ($urandom_range(1, 12)) rec_q.push_back(8'($urandom_range(0, 255)));
    end
    push_record(drain_first);
  endtask

  // Mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- driver ----------------

  int unsigned tx_gap;
  int unsigned tx_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i <= '0;
      tx_gap = 0;
      tx_calm = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        byte_reports_q.push_back(parse_byte(in_i));
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          tx_gap = draw_gap();
          if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(20, 80);
        end
      end
      // hold a stalled transfer, else pick the next one
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (stream_q.size() > 0 &&
                     !(stream_q[0].drain && byte_reports_q.size() > 0)) begin
          in_i <= stream_q[0].item;
          in_valid_i <= 1'b1;
          void'(stream_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  int unsigned rx_cnt;
  int unsigned rx_hold;
  int unsigned rx_calm;

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_cnt = 0;
      rx_hold = 0;
      rx_calm = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (byte_reports_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 40)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_o);
        end else begin
          want = byte_reports_q.pop_front();
          check_field("byte_role", want.byte_role, out_o.byte_role);
          check_field("entry_index", want.entry_index, out_o.entry_index);
          check_field("byte_offset", want.byte_offset, out_o.byte_offset);
          check_field("keep", want.keep, out_o.keep);
          check_field("entry_done", want.entry_done, out_o.entry_done);
          check_field("entry_type", want.entry_type, out_o.entry_type);
          check_field("int_value", want.int_value, out_o.int_value);
          check_field("bool_value", want.bool_value, out_o.bool_value);
          check_field("end_of_buffer", want.end_of_buffer, out_o.end_of_buffer);
          check_field("entry_count", want.entry_count, out_o.entry_count);
          check_field("stop_reason", want.stop_reason, out_o.stop_reason);
        end
        rx_cnt++;
        // one long hold lets the input side back up
        if (rx_cnt == HoldAtCount) begin
          rx_hold = HoldCycles;
        end else if (rx_calm > 0) begin
          rx_calm--;
          rx_hold = 0;
        end else begin
          rx_hold = draw_gap();
          if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(20, 80);
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    int unsigned next_drain;
    clear_parse();

    // int -32768 with a one byte key, true bool, empty string: clean end
    rec_q = '{8'h01, 8'h41, TYPE_INT16, 8'h00, 8'h80,
              8'h00, TYPE_BOOL, 8'hFF,
              8'h00, TYPE_STRING, 8'h00};
    push_record(1'b0);
    // int 32767 and false bool
    rec_q = '{8'h00, TYPE_INT16, 8'hFF, 8'h7F, 8'h00, TYPE_BOOL, 8'h00};
    push_record(1'b0);
    // unknown type halts, trailing byte ignored
    rec_q = '{8'h00, 8'hFF, 8'h12};
    push_record(1'b0);
    // lone trailing key length
    rec_q = '{8'h05};
    push_record(1'b0);
    // string cut short
    rec_q = '{8'h00, TYPE_STRING, 8'h03, 8'h78};
    push_record(1'b0);
    // full-range key and string lengths
    rec_q.push_back(8'hFF);
    repeat (255) rec_q.push_back(8'($urandom_range(0, 255)));
    rec_q.push_back(TYPE_STRING);
    rec_q.push_back(8'hFF);
    repeat (255) rec_q.push_back(8'($urandom_range(0, 255)));
    push_record(1'b1);

    next_drain = stream_q.size() + DrainEvery;
    while (stream_q.size() < StreamBytes) begin
      if (stream_q.size() >= next_drain) begin
        add_buffer(1'b1);
        next_drain += DrainEvery;
      end else begin
        add_buffer(1'b0);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stream_q.size() == 0 && !in_valid_i && byte_reports_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tkvrp_pkg.sv
rtl/core/typed_key_value_record_parser_core.sv
bench/tb.sv
